### design/hpt_pkg.sv
// Shared types and constants for the homogeneous point transform unit.
`timescale 1ns / 1ps
package hpt_pkg;
  localparam int COEF_W = 32;             // one Q.F matrix coefficient or coordinate
  localparam int REG_W  = 64;             // one configuration register (two coefficients)
  localparam int NREG   = 8;              // two registers per matrix row
  localparam int IDX_W  = 3;              // register index width
  localparam int PROD_W = 64;             // exact 32x32 signed product
  localparam int SUM_W  = 66;             // exact signed sum of four products
  localparam int MAG_W  = 65;             // magnitude of a row sum
  localparam int Q_W    = 33;             // quotient bits formed by the divider
  localparam int NLANE  = 3;              // x, y, z

  // One classified item passed from the front end to the divider
  typedef struct packed {
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] sz;
    logic [MAG_W-1:0]        den;         // |w| when dividing, 2^(2F) otherwise
    logic                    w_neg;
    logic                    divide;
  } entry_t;
endpackage

### design/hpt_front.sv
// Front end: matrix registers, products, row sums and w classification.
`timescale 1ns / 1ps
module hpt_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [hpt_pkg::IDX_W-1:0]    cfg_index,
  input  logic [hpt_pkg::REG_W-1:0]    cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [31:0]           in_pos_x,
  input  logic signed [31:0]           in_pos_y,
  input  logic signed [31:0]           in_pos_z,
  output logic                         push,
  output hpt_pkg::entry_t              push_entry,
  input  logic                         q_full
);
  import hpt_pkg::*;

  localparam logic [REG_W-1:0] ONE_LO = REG_W'(1) << FRAC_BITS;
  localparam logic [REG_W-1:0] ONE_HI = REG_W'(1) << (FRAC_BITS + COEF_W);
  localparam logic [MAG_W-1:0] ONE_2F = MAG_W'(1) << (2 * FRAC_BITS);

  logic [REG_W-1:0]        mat_r [NREG];
  logic                    v1_r, v2_r;
  logic                    adv;
  logic signed [PROD_W-1:0] prod_r [4][4];
  logic signed [PROD_W-1:0] prod_nxt [4][4];
  logic signed [SUM_W-1:0]  sum_r [4];
  logic signed [SUM_W-1:0]  sum_nxt [4];
  logic signed [COEF_W-1:0] vec [3];
  logic signed [COEF_W-1:0] cf;
  logic [SUM_W-1:0]         w_abs;
  logic                     w_zero, w_one;

  // Stall the whole front end only when the last stage cannot push
  assign adv      = !v2_r || !q_full;
  assign in_ready = adv;
  assign push     = v2_r && !q_full;

  // Write matrix registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r[0] <= ONE_LO;
      mat_r[1] <= '0;
      mat_r[2] <= ONE_HI;
      mat_r[3] <= '0;
      mat_r[4] <= '0;
      mat_r[5] <= ONE_LO;
      mat_r[6] <= '0;
      mat_r[7] <= ONE_HI;
    end else if (cfg_we) begin
      mat_r[cfg_index] <= cfg_wdata;
    end
  end

  // Form the sixteen exact products; the w column is a shift
  always_comb begin
    vec[0] = in_pos_x;
    vec[1] = in_pos_y;
    vec[2] = in_pos_z;
    cf     = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        cf = mat_r[r*2 + c/2][(c%2)*COEF_W +: COEF_W];
        if (c == 3) begin
          prod_nxt[r][c] = PROD_W'(cf) <<< FRAC_BITS;
        end else begin
          prod_nxt[r][c] = PROD_W'(cf) * PROD_W'(vec[c]);
        end
      end
    end
  end

  // Add each row
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum_nxt[r] = SUM_W'(prod_r[r][0]) + SUM_W'(prod_r[r][1])
                 + SUM_W'(prod_r[r][2]) + SUM_W'(prod_r[r][3]);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      sum_r  <= sum_nxt;
    end
  end

  // Classify w and pick the divisor
  always_comb begin
    w_abs  = sum_r[3][SUM_W-1] ? SUM_W'(-sum_r[3]) : SUM_W'(sum_r[3]);
    w_zero = (sum_r[3] == '0);
    w_one  = (sum_r[3] == SUM_W'(ONE_2F));
    push_entry.sx     = sum_r[0];
    push_entry.sy     = sum_r[1];
    push_entry.sz     = sum_r[2];
    push_entry.divide = !(w_zero || w_one);
    push_entry.w_neg  = push_entry.divide && sum_r[3][SUM_W-1];
    push_entry.den    = push_entry.divide ? w_abs[MAG_W-1:0] : ONE_2F;
  end
endmodule

### design/hpt_queue.sv
// Short item queue between the front end and the divider.
`timescale 1ns / 1ps
module hpt_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hpt_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output hpt_pkg::entry_t head
);
  import hpt_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rp_r];

  // Move pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      if (pop)  rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  // Store the item
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_entry;
  end
endmodule

### design/hpt_back.sv
// Back end: pipelined restoring divider per lane, clamp and output register.
`timescale 1ns / 1ps
module hpt_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  hpt_pkg::entry_t    q_entry,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               out_divided,
  output logic               out_saturated
);
  import hpt_pkg::*;

  localparam int NW = MAG_W + FRAC_BITS;   // numerator |s| * 2^F
  localparam int TW = NW - Q_W;            // numerator bits above the quotient range
  localparam logic [Q_W-1:0] POS_MAX = Q_W'(32'h7FFF_FFFF);
  localparam logic [Q_W-1:0] NEG_MAX = Q_W'(33'h0_8000_0000);

  logic                 adv;
  logic                 vld_r   [Q_W+1];
  logic [MAG_W-1:0]     den_r   [Q_W+1];
  logic                 div_r   [Q_W+1];
  logic [MAG_W-1:0]     rem_r   [Q_W+1][NLANE];
  logic [Q_W-1:0]       nlo_r   [Q_W+1][NLANE];
  logic [Q_W-1:0]       quo_r   [Q_W+1][NLANE];
  logic                 neg_r   [Q_W+1][NLANE];
  logic                 ovf_r   [Q_W+1][NLANE];
  logic [MAG_W-1:0]     rem_nxt [Q_W+1][NLANE];
  logic [Q_W-1:0]       nlo_nxt [Q_W+1][NLANE];
  logic [Q_W-1:0]       quo_nxt [Q_W+1][NLANE];
  logic                 neg_nxt [Q_W+1][NLANE];
  logic                 ovf_nxt [Q_W+1][NLANE];
  logic signed [SUM_W-1:0] s_in [NLANE];
  logic [SUM_W-1:0]     mag   [NLANE];
  logic [NW-1:0]        num   [NLANE];
  logic [TW-1:0]        top   [NLANE];
  logic                 out_valid_r;
  logic [31:0]          res   [NLANE];
  logic [NLANE-1:0]     sat;
  logic                 zero_q, neg_f;
  logic [Q_W-1:0]       qf;

  // Move the whole back end when the output register can load
  assign adv       = !out_valid_r || out_ready;
  assign q_pop     = adv && q_valid;
  assign out_valid = out_valid_r;

  // Entry stage: magnitudes, sign and overflow check against den * 2^Q_W
  always_comb begin
    s_in[0] = q_entry.sx;
    s_in[1] = q_entry.sy;
    s_in[2] = q_entry.sz;
    for (int l = 0; l < NLANE; l++) begin
      mag[l] = s_in[l][SUM_W-1] ? SUM_W'(-s_in[l]) : SUM_W'(s_in[l]);
      num[l] = {mag[l][MAG_W-1:0], {FRAC_BITS{1'b0}}};
      top[l] = num[l][NW-1:Q_W];
      ovf_nxt[0][l] = (MAG_W'(top[l]) >= q_entry.den);
      rem_nxt[0][l] = MAG_W'(top[l]);
      nlo_nxt[0][l] = num[l][Q_W-1:0];
      quo_nxt[0][l] = '0;
      neg_nxt[0][l] = s_in[l][SUM_W-1] ^ q_entry.w_neg;
    end
  end

  // One quotient bit per stage and lane
  for (genvar k = 1; k <= Q_W; k++) begin : g_step
    logic [MAG_W:0] part [NLANE];
    logic [MAG_W:0] diff [NLANE];
    logic           ge   [NLANE];

    always_comb begin
      for (int l = 0; l < NLANE; l++) begin
        part[l] = {rem_r[k-1][l], nlo_r[k-1][l][Q_W-1]};
        diff[l] = part[l] - {1'b0, den_r[k-1]};
        ge[l]   = (part[l] >= {1'b0, den_r[k-1]});
        rem_nxt[k][l] = ge[l] ? diff[l][MAG_W-1:0] : part[l][MAG_W-1:0];
        nlo_nxt[k][l] = nlo_r[k-1][l] << 1;
        quo_nxt[k][l] = {quo_r[k-1][l][Q_W-2:0], ge[l]};
        neg_nxt[k][l] = neg_r[k-1][l];
        ovf_nxt[k][l] = ovf_r[k-1][l];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        den_r[k] <= den_r[k-1];
        div_r[k] <= div_r[k-1];
        rem_r[k] <= rem_nxt[k];
        nlo_r[k] <= nlo_nxt[k];
        quo_r[k] <= quo_nxt[k];
        neg_r[k] <= neg_nxt[k];
        ovf_r[k] <= ovf_nxt[k];
      end
    end
  end

  // Load entry stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den_r[0] <= q_entry.den;
      div_r[0] <= q_entry.divide;
      rem_r[0] <= rem_nxt[0];
      nlo_r[0] <= nlo_nxt[0];
      quo_r[0] <= quo_nxt[0];
      neg_r[0] <= neg_nxt[0];
      ovf_r[0] <= ovf_nxt[0];
    end
  end

  // Apply sign and clamp to 32 bits
  always_comb begin
    zero_q = 1'b0;
    neg_f  = 1'b0;
    qf     = '0;
    for (int l = 0; l < NLANE; l++) begin
      qf     = quo_r[Q_W][l];
      zero_q = !ovf_r[Q_W][l] && (qf == '0);
      neg_f  = neg_r[Q_W][l] && !zero_q;
      if (neg_f) begin
        sat[l] = ovf_r[Q_W][l] || (qf > NEG_MAX);
        res[l] = sat[l] ? 32'h8000_0000 : 32'(-qf[31:0]);
      end else begin
        sat[l] = ovf_r[Q_W][l] || (qf > POS_MAX);
        res[l] = sat[l] ? 32'h7FFF_FFFF : qf[31:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x         <= res[0];
      out_y         <= res[1];
      out_z         <= res[2];
      out_divided   <= div_r[Q_W];
      out_saturated <= |sat;
    end
  end
endmodule

### design/homogeneous_point_transform_unit.sv
// Top level of the homogeneous point transform unit.
// Transforms one Q.F point (x, y, z, 1) by a 4x4 matrix and divides x, y, z
// by w unless w is zero or exactly one. The unit takes one item per clock
// cycle sustained while the output is not stalled. An item passes through
// the product and row-sum registers, the queue, the divider entry stage and
// quotient stages, and the output register; output stalls hold it. Most of
// the pipeline is the per-lane restoring divider, which forms one of its
// 33 quotient bits per pipeline stage. The matrix resets to the identity;
// registers are written through cfg_we, cfg_index and cfg_wdata; the user
// must write them only while no item is in flight, which the block itself
// does not enforce.
`timescale 1ns / 1ps
module homogeneous_point_transform_unit #(
  parameter int FRAC_BITS = 16,
  parameter int QDEPTH    = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [hpt_pkg::IDX_W-1:0] cfg_index,
  input  logic [hpt_pkg::REG_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [31:0]        in_pos_x,
  input  logic signed [31:0]        in_pos_y,
  input  logic signed [31:0]        in_pos_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [31:0]        out_x,
  output logic signed [31:0]        out_y,
  output logic signed [31:0]        out_z,
  output logic                      out_divided,
  output logic                      out_saturated
);
  import hpt_pkg::*;

  logic   push, q_full, q_pop, q_valid;
  entry_t push_entry, q_head;

  hpt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_pos_x, .in_pos_y, .in_pos_z,
    .push, .push_entry, .q_full
  );

  hpt_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk, .rst_n, .push, .push_entry, .full(q_full),
    .pop(q_pop), .not_empty(q_valid), .head(q_head)
  );

  hpt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_entry(q_head), .q_pop,
    .out_valid, .out_ready, .out_x, .out_y, .out_z,
    .out_divided, .out_saturated
  );
endmodule

### design/hpt_checker.sv
// Port-level checks for the homogeneous point transform unit.
`timescale 1ns / 1ps
module hpt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_x,
  input logic signed [31:0] out_y,
  input logic signed [31:0] out_z,
  input logic               out_saturated
);
  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // Queue is empty after reset so an item can enter
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  // A saturated item shows a clamped component
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_x == 32'sh7FFF_FFFF || out_x == 32'sh8000_0000 ||
      out_y == 32'sh7FFF_FFFF || out_y == 32'sh8000_0000 ||
      out_z == 32'sh7FFF_FFFF || out_z == 32'sh8000_0000)
    else $error("saturated flag without a clamped component");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_z))
    else $error("stalled item changed");
endmodule

bind homogeneous_point_transform_unit hpt_checker u_hpt_checker (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready,
  .out_x, .out_y, .out_z, .out_saturated
);
